// ===== src/morse_code_table_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Morse code table engine assertion macros
// Shared property forms for the interface checker.
// ----------------------------------------------------------------------------
`ifndef MORSE_CODE_TABLE_ENGINE_DEFINES_SVH
`define MORSE_CODE_TABLE_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mcte_pkg.sv =====
// ----------------------------------------------------------------------------
// Morse code table engine package
// Field widths, command and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package mcte_pkg;

	localparam int CMD_W      = 2;
	localparam int CHAR_W     = 8;
	localparam int CODE_BITS_W = 6;
	localparam int CODE_LEN_W = 3;
	localparam int STATUS_W   = 2;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DECODE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_ADDED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

	localparam logic [CHAR_W-1:0] BLANK_SYMBOL = 8'd95;

	typedef enum logic [2:0] {
		RES_OK,
		RES_NOT_ADDED,
		RES_NOT_FOUND,
		RES_EMPTY,
		RES_DECODE,
		RES_ENCODE
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     clear;
		logic     walk_step;
		logic     write_char;
		logic     rd_node;
		logic     scan_start;
		logic     scan_step;
		logic     finish;
		res_sel_t res_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             root_present;
		logic             walk_done;
		logic             child_present;
		logic             has_children;
		logic             scan_end;
		logic             scan_hit;
		logic             out_busy;
	} dp_stat_t;

endpackage

// ===== src/morse_code_table_engine.sv =====
// ----------------------------------------------------------------------------
// Morse code table engine
// Morse code trie kept as a heap-indexed table, with add, decode, encode and
// clear commands.
//
//   Channel   Handshake            Beat contents
//   request   req_valid/req_stall  command, character, code_bits, code_length
//   response  rsp_valid/rsp_stall  result_character, result_code_bits,
//                                  result_code_length, status
//
// Add and decode walk the code path one symbol per cycle.
// Encode scans the symbol memory one node per cycle through its single read
// port, until it finds the character or reaches the last node.
// Reset empties the table at once through the presence flip-flops.
// A stalled response holds in the output register while the next request is
// taken; its own reply then waits for that register to drain.
// ----------------------------------------------------------------------------
module morse_code_table_engine import mcte_pkg::*; #(
	parameter int MAX_CODE_SYMBOLS = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [CMD_W-1:0]       command,
	input  logic [CHAR_W-1:0]      character,
	input  logic [CODE_BITS_W-1:0] code_bits,
	input  logic [CODE_LEN_W-1:0]  code_length,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic [CHAR_W-1:0]      result_character,
	output logic [CODE_BITS_W-1:0] result_code_bits,
	output logic [CODE_LEN_W-1:0]  result_code_length,
	output logic [STATUS_W-1:0]    status
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	mcte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	mcte_datapath #(
		.MAX_CODE_SYMBOLS(MAX_CODE_SYMBOLS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (dp_cmd),
		.stat              (dp_stat),
		.command           (command),
		.character         (character),
		.code_bits         (code_bits),
		.code_length       (code_length),
		.rsp_valid         (rsp_valid),
		.rsp_stall         (rsp_stall),
		.result_character  (result_character),
		.result_code_bits  (result_code_bits),
		.result_code_length(result_code_length),
		.status            (status)
	);

endmodule

// ===== src/mcte_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mcte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/mcte_datapath.sv =====
// ----------------------------------------------------------------------------
// Morse code table engine datapath
// Node presence bits, symbol memory, path walker, table scanner and the
// result register.
// ----------------------------------------------------------------------------
module mcte_datapath import mcte_pkg::*; #(
	parameter int MAX_CODE_SYMBOLS = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	output dp_stat_t               stat,
	input  logic [CMD_W-1:0]       command,
	input  logic [CHAR_W-1:0]      character,
	input  logic [CODE_BITS_W-1:0] code_bits,
	input  logic [CODE_LEN_W-1:0]  code_length,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic [CHAR_W-1:0]      result_character,
	output logic [CODE_BITS_W-1:0] result_code_bits,
	output logic [CODE_LEN_W-1:0]  result_code_length,
	output logic [STATUS_W-1:0]    status
);

	localparam int NODE_W     = MAX_CODE_SYMBOLS + 1;
	localparam int TABLE_SIZE = 1 << NODE_W;
	localparam int LEN_W      = $clog2(MAX_CODE_SYMBOLS + 1);
	localparam logic [NODE_W-1:0] ROOT_NODE  = NODE_W'(1);
	localparam logic [NODE_W-1:0] FIRST_SCAN = NODE_W'(2);
	localparam logic [NODE_W-1:0] LAST_SCAN  = {NODE_W{1'b1}};

	logic [CMD_W-1:0]       cmd_q;
	logic [CHAR_W-1:0]      char_q;
	logic [CODE_BITS_W-1:0] bits_q;
	logic [LEN_W-1:0]       len_q;
	logic [LEN_W-1:0]       step_q;
	logic [NODE_W-1:0]      node_q;
	logic [TABLE_SIZE-1:0]  present_q;
	logic [NODE_W-1:0]      scan_q;
	logic                   issued_q;
	logic                   look_s1;
	logic [NODE_W-1:0]      idx_s1;
	logic [NODE_W-1:0]      found_q;

	logic                   out_valid_q;
	logic [CHAR_W-1:0]      out_char_q;
	logic [CODE_BITS_W-1:0] out_bits_q;
	logic [CODE_LEN_W-1:0]  out_len_q;
	logic [STATUS_W-1:0]    out_status_q;

	logic [LEN_W-1:0]       len_clamped;
	logic                   dash;
	logic [NODE_W-1:0]      child;
	logic                   hit;
	logic                   ram_wr_en;
	logic [NODE_W-1:0]      ram_wr_addr;
	logic [CHAR_W-1:0]      ram_wr_data;
	logic                   ram_rd_en;
	logic [NODE_W-1:0]      ram_rd_addr;
	logic [CHAR_W-1:0]      ram_rd_data;
	logic [LEN_W-1:0]       enc_depth;
	logic [CODE_BITS_W-1:0] enc_bits;

	assign len_clamped = (int'(code_length) > MAX_CODE_SYMBOLS) ?
		LEN_W'(MAX_CODE_SYMBOLS) : LEN_W'(code_length);

	always_comb begin
		dash = 1'b0;
		for (int k = 0; k < CODE_BITS_W; k++) begin
			if (int'(step_q) == k) begin
				dash = bits_q[k];
			end
		end
	end

	if (NODE_W > 1) begin : g_child
		assign child = {node_q[NODE_W-2:0], dash};
	end

	assign hit = look_s1 && present_q[idx_s1] && (ram_rd_data == char_q);

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = node_q;
		ram_wr_data = BLANK_SYMBOL;
		if (cmd.load && (command == CMD_ADD) && !present_q[ROOT_NODE]) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = ROOT_NODE;
		end else if (cmd.walk_step && (cmd_q == CMD_ADD) && !present_q[child]) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = child;
		end else if (cmd.write_char) begin
			ram_wr_en   = 1'b1;
			ram_wr_data = char_q;
		end
	end

	assign ram_rd_en   = cmd.rd_node || cmd.scan_step;
	assign ram_rd_addr = cmd.scan_step ? scan_q : node_q;

	mcte_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(TABLE_SIZE)
	) u_symbol_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (cmd.clear) begin
			present_q <= '0;
		end else if (cmd.load && (command == CMD_ADD)) begin
			present_q[ROOT_NODE] <= 1'b1;
		end else if (cmd.walk_step && (cmd_q == CMD_ADD)) begin
			present_q[child] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q    <= CMD_ADD;
			step_q   <= '0;
			node_q   <= ROOT_NODE;
			scan_q   <= FIRST_SCAN;
			issued_q <= 1'b0;
			look_s1  <= 1'b0;
		end else begin
			if (cmd.load) begin
				cmd_q  <= command;
				step_q <= '0;
				node_q <= ROOT_NODE;
			end else if (cmd.walk_step) begin
				step_q <= step_q + LEN_W'(1);
				node_q <= child;
			end
			if (cmd.scan_start) begin
				scan_q   <= FIRST_SCAN;
				issued_q <= 1'b0;
				look_s1  <= 1'b0;
			end else if (cmd.scan_step) begin
				look_s1 <= !issued_q;
				if (scan_q == LAST_SCAN) begin
					issued_q <= 1'b1;
				end else begin
					scan_q <= scan_q + NODE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q <= character;
			bits_q <= code_bits;
			len_q  <= len_clamped;
		end
		if (cmd.scan_step) begin
			idx_s1 <= scan_q;
		end
		if (cmd.scan_step && hit) begin
			found_q <= idx_s1;
		end
	end

	always_comb begin
		enc_depth = '0;
		for (int k = 1; k < NODE_W; k++) begin
			if (found_q[k]) begin
				enc_depth = LEN_W'(k);
			end
		end
	end

	always_comb begin
		enc_bits = '0;
		for (int j = 0; j < CODE_BITS_W; j++) begin
			for (int p = 0; p < NODE_W - 1; p++) begin
				if (p + j + 1 == int'(enc_depth)) begin
					enc_bits[j] = found_q[p];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_char_q   <= '0;
			out_bits_q   <= '0;
			out_len_q    <= '0;
			out_status_q <= ST_OK;
			case (cmd.res_sel)
				RES_OK: begin
					out_status_q <= ST_OK;
				end
				RES_NOT_ADDED: begin
					out_status_q <= ST_NOT_ADDED;
				end
				RES_NOT_FOUND: begin
					out_status_q <= ST_NOT_FOUND;
				end
				RES_EMPTY: begin
					out_status_q <= ST_EMPTY;
				end
				RES_DECODE: begin
					out_char_q <= ram_rd_data;
				end
				RES_ENCODE: begin
					out_bits_q <= enc_bits;
					out_len_q  <= CODE_LEN_W'(int'(enc_depth));
				end
				default: begin
					out_status_q <= ST_OK;
				end
			endcase
		end
	end

	assign rsp_valid          = out_valid_q;
	assign result_character   = out_char_q;
	assign result_code_bits   = out_bits_q;
	assign result_code_length = out_len_q;
	assign status             = out_status_q;

	assign stat.cmd           = cmd_q;
	assign stat.root_present  = present_q[ROOT_NODE];
	assign stat.walk_done     = (step_q == len_q);
	assign stat.child_present = present_q[child];
	assign stat.has_children  = !node_q[NODE_W-1] &&
		(present_q[{node_q[NODE_W-2:0], 1'b0}] || present_q[{node_q[NODE_W-2:0], 1'b1}]);
	assign stat.scan_end      = look_s1 && (hit || (idx_s1 == LAST_SCAN));
	assign stat.scan_hit      = hit;
	assign stat.out_busy      = out_valid_q && rsp_stall;

endmodule

// ===== src/mcte_ctrl.sv =====
// ----------------------------------------------------------------------------
// Morse code table engine controller
// Sequences add, decode, encode and clear over the datapath.
// ----------------------------------------------------------------------------
module mcte_ctrl import mcte_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DISPATCH = 6'b000010,
		S_WALK     = 6'b000100,
		S_ADD_END  = 6'b001000,
		S_SCAN     = 6'b010000,
		S_REPLY    = 6'b100000
	} state_t;

	state_t   state_q;
	state_t   state_d;
	res_sel_t res_q;
	res_sel_t res_d;

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.res_sel = res_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.cmd)
					CMD_ADD: begin
						state_d = S_WALK;
					end
					CMD_DECODE: begin
						if (stat.root_present) begin
							state_d = S_WALK;
						end else begin
							res_d   = RES_EMPTY;
							state_d = S_REPLY;
						end
					end
					CMD_ENCODE: begin
						if (stat.root_present) begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end else begin
							res_d   = RES_EMPTY;
							state_d = S_REPLY;
						end
					end
					default: begin
						cmd.clear = 1'b1;
						res_d     = RES_OK;
						state_d   = S_REPLY;
					end
				endcase
			end
			S_WALK: begin
				if (stat.walk_done) begin
					if (stat.cmd == CMD_ADD) begin
						state_d = S_ADD_END;
					end else begin
						cmd.rd_node = 1'b1;
						res_d       = RES_DECODE;
						state_d     = S_REPLY;
					end
				end else if ((stat.cmd == CMD_ADD) || stat.child_present) begin
					cmd.walk_step = 1'b1;
				end else begin
					res_d   = RES_NOT_FOUND;
					state_d = S_REPLY;
				end
			end
			S_ADD_END: begin
				if (stat.has_children) begin
					res_d = RES_NOT_ADDED;
				end else begin
					cmd.write_char = 1'b1;
					res_d          = RES_OK;
				end
				state_d = S_REPLY;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_end) begin
					res_d   = stat.scan_hit ? RES_ENCODE : RES_NOT_FOUND;
					state_d = S_REPLY;
				end
			end
			S_REPLY: begin
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= RES_OK;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

// ===== src/mcte_checker.sv =====
// ----------------------------------------------------------------------------
// Morse code table engine interface checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "morse_code_table_engine_defines.svh"

module mcte_checker import mcte_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_stall,
	input logic                   rsp_valid,
	input logic                   rsp_stall,
	input logic [CHAR_W-1:0]      result_character,
	input logic [CODE_BITS_W-1:0] result_code_bits,
	input logic [CODE_LEN_W-1:0]  result_code_length,
	input logic [STATUS_W-1:0]    status
);

	logic req_fire;
	logic rsp_hold;
	logic rsp_empty;
	logic rsp_coded;
	logic rsp_blank;
	logic [CHAR_W+CODE_BITS_W+CODE_LEN_W+STATUS_W-1:0] rsp_beat;

	assign req_fire  = req_valid && !req_stall;
	assign rsp_hold  = rsp_valid && rsp_stall;
	assign rsp_empty = rsp_valid && (status == ST_EMPTY);
	assign rsp_coded = rsp_valid && (result_code_length != '0);
	assign rsp_blank = (result_character == '0) && (result_code_length == '0) &&
		(result_code_bits == '0);
	assign rsp_beat  = {result_character, result_code_bits, result_code_length, status};

	`MCTE_ASSERT_NEXT(a_one_item_at_a_time, req_fire, req_stall, "request taken while busy")
	`MCTE_ASSERT_NOW(a_reply_after_work, $rose(rsp_valid), $past(req_stall), "reply without work")
	`MCTE_ASSERT_NOW(a_empty_is_blank, rsp_empty, rsp_blank, "empty reply carries data")
	`MCTE_ASSERT_NOW(a_code_only_on_ok, rsp_coded, status == ST_OK, "code with error status")
	`MCTE_ASSERT_NEXT(a_reply_holds, rsp_hold, rsp_valid && $stable(rsp_beat), "reply changed")

endmodule

bind morse_code_table_engine mcte_checker u_mcte_checker (.*);

// ===== verif/morse_table_checker.sv =====
// ----------------------------------------------------------------------------
// Morse code table checker
// Watches the request and response channels of the Morse code table engine.
// It keeps its own copy of the heap-indexed trie and works out the reply to
// every accepted request beat. Each response beat is compared field by field
// with the oldest reply still owed.
// ----------------------------------------------------------------------------
module morse_table_checker import mcte_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic                   req_stall,
	input  logic [CMD_W-1:0]       command,
	input  logic [CHAR_W-1:0]      character,
	input  logic [CODE_BITS_W-1:0] code_bits,
	input  logic [CODE_LEN_W-1:0]  code_length,
	input  logic                   rsp_valid,
	input  logic                   rsp_stall,
	input  logic [CHAR_W-1:0]      result_character,
	input  logic [CODE_BITS_W-1:0] result_code_bits,
	input  logic [CODE_LEN_W-1:0]  result_code_length,
	input  logic [STATUS_W-1:0]    status,
	output int                     mismatch_count,
	output int                     replies_pending,
	output int                     replies_checked
);

	localparam int MAX_SYMBOLS = 6;
	localparam int NODE_COUNT  = 1 << (MAX_SYMBOLS + 1);
	localparam int PRINT_LIMIT = 40;
	localparam int OWED_DEPTH  = 8;

	typedef struct packed {
		logic [CHAR_W-1:0]      chr;
		logic [CODE_BITS_W-1:0] code;
		logic [CODE_LEN_W-1:0]  len;
		logic [STATUS_W-1:0]    status;
	} morse_reply_t;

	logic [CHAR_W-1:0] node_char [NODE_COUNT];
	logic              node_used [NODE_COUNT];
	morse_reply_t      replies_owed [OWED_DEPTH];
	int                owed_wr;
	int                owed_rd;

	function automatic void empty_table();
		for (int i = 0; i < NODE_COUNT; i++) begin
			node_char[i] = BLANK_SYMBOL;
			node_used[i] = 1'b0;
		end
	endfunction

	function automatic morse_reply_t run_command(
		input logic [CMD_W-1:0]       cmd,
		input logic [CHAR_W-1:0]      ch,
		input logic [CODE_BITS_W-1:0] code,
		input logic [CODE_LEN_W-1:0]  len_in
	);
		morse_reply_t r;
		int           len;
		int           node;
		int           hit;
		int           depth;
		int           t;
		logic         ok;
		r = '0;
		r.status = ST_OK;
		len = (len_in > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(len_in);
		node = 1;
		case (cmd)
			CMD_ADD: begin
				for (int k = 0; k <= len; k++) begin
					if (k > 0)
						node = (node << 1) | int'(code[k-1]);
					if (!node_used[node]) begin
						node_used[node] = 1'b1;
						node_char[node] = BLANK_SYMBOL;
					end
				end
				if (node < NODE_COUNT / 2 && (node_used[2*node] || node_used[2*node+1]))
					r.status = ST_NOT_ADDED;
				else
					node_char[node] = ch;
			end
			CMD_DECODE: begin
				if (!node_used[1]) begin
					r.status = ST_EMPTY;
				end else begin
					ok = 1'b1;
					for (int k = 0; k < len && ok; k++) begin
						node = (node << 1) | int'(code[k]);
						ok = node_used[node];
					end
					if (ok)
						r.chr = node_char[node];
					else
						r.status = ST_NOT_FOUND;
				end
			end
			CMD_ENCODE: begin
				if (!node_used[1]) begin
					r.status = ST_EMPTY;
				end else begin
					hit = 0;
					for (int i = NODE_COUNT - 1; i >= 2; i--)
						if (node_used[i] && node_char[i] == ch)
							hit = i;
					if (hit == 0) begin
						r.status = ST_NOT_FOUND;
					end else begin
						depth = 0;
						t = hit;
						while (t > 1) begin
							t = t >> 1;
							depth++;
						end
						for (int j = 0; j < depth; j++)
							r.code[j] = 1'((hit >> (depth - 1 - j)) & 1);
						r.len = CODE_LEN_W'(depth);
					end
				end
			end
			CMD_CLEAR: begin
				empty_table();
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		morse_reply_t want;
		if (!arst_n) begin
			empty_table();
			owed_wr = 0;
			owed_rd = 0;
			replies_pending = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				replies_checked++;
				if (owed_wr == owed_rd) begin
					report_mismatch("response beat with no reply owed");
				end else begin
					want = replies_owed[owed_rd % OWED_DEPTH];
					owed_rd++;
					if (result_character !== want.chr)
						report_mismatch($sformatf("result_character expected %0d got %0d",
							want.chr, result_character));
					if (result_code_bits !== want.code)
						report_mismatch($sformatf("result_code_bits expected %0d got %0d",
							want.code, result_code_bits));
					if (result_code_length !== want.len)
						report_mismatch($sformatf("result_code_length expected %0d got %0d",
							want.len, result_code_length));
					if (status !== want.status)
						report_mismatch($sformatf("status expected %0d got %0d",
							want.status, status));
				end
			end
			if (req_valid && !req_stall) begin
				if (owed_wr - owed_rd == OWED_DEPTH) begin
					report_mismatch("more request beats in flight than the engine can hold");
				end else begin
					replies_owed[owed_wr % OWED_DEPTH] =
						run_command(command, character, code_bits, code_length);
					owed_wr++;
				end
			end
			replies_pending = owed_wr - owed_rd;
		end
	end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Morse code table engine testbench
// Drives add, decode, encode and clear requests into the engine: first a
// directed run over the corner cases of the trie, then random phases that mix
// adds, clears and lookups; many lookups use codes and characters already added.
// Both channels idle at random; one phase holds the response side off for a
// long stretch. The checker beside the engine predicts every reply.
// ----------------------------------------------------------------------------
module tb;
	import mcte_pkg::*;

	localparam int HOLD_OFF_CYCLES = 400;
	localparam int STALL_LIMIT     = 5000;
	localparam int PHASE_BEATS     = 250;
	localparam int PHASES          = 6;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   req_valid = 1'b0;
	logic                   req_stall;
	logic [CMD_W-1:0]       command = CMD_ADD;
	logic [CHAR_W-1:0]      character = '0;
	logic [CODE_BITS_W-1:0] code_bits = '0;
	logic [CODE_LEN_W-1:0]  code_length = '0;
	logic                   rsp_valid;
	logic                   rsp_stall = 1'b0;
	logic [CHAR_W-1:0]      result_character;
	logic [CODE_BITS_W-1:0] result_code_bits;
	logic [CODE_LEN_W-1:0]  result_code_length;
	logic [STATUS_W-1:0]    status;

	int mismatch_count;
	int replies_pending;
	int replies_checked;
	int beats_sent [4];
	int idle_cycles;
	logic no_idle = 1'b0;
	logic hold_off_req = 1'b0;

	logic [CODE_BITS_W-1:0] known_bits [16];
	logic [CODE_LEN_W-1:0]  known_len [16];
	logic [CHAR_W-1:0]      known_chars [16];

	morse_code_table_engine dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.req_valid          (req_valid),
		.req_stall          (req_stall),
		.command            (command),
		.character          (character),
		.code_bits          (code_bits),
		.code_length        (code_length),
		.rsp_valid          (rsp_valid),
		.rsp_stall          (rsp_stall),
		.result_character   (result_character),
		.result_code_bits   (result_code_bits),
		.result_code_length (result_code_length),
		.status             (status)
	);

	morse_table_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.req_valid          (req_valid),
		.req_stall          (req_stall),
		.command            (command),
		.character          (character),
		.code_bits          (code_bits),
		.code_length        (code_length),
		.rsp_valid          (rsp_valid),
		.rsp_stall          (rsp_stall),
		.result_character   (result_character),
		.result_code_bits   (result_code_bits),
		.result_code_length (result_code_length),
		.status             (status),
		.mismatch_count     (mismatch_count),
		.replies_pending    (replies_pending),
		.replies_checked    (replies_checked)
	);

	always #6 clk = ~clk;

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_beat(
		input logic [CMD_W-1:0]       cmd,
		input logic [CHAR_W-1:0]      ch,
		input logic [CODE_BITS_W-1:0] bits,
		input logic [CODE_LEN_W-1:0]  len
	);
		int gap;
		command <= cmd;
		character <= ch;
		code_bits <= bits;
		code_length <= len;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		beats_sent[cmd]++;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_replies();
		req_valid <= 1'b0;
		do @(posedge clk); while (replies_pending != 0);
	endtask

	initial begin : receiver
		int hold;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (no_idle) begin
				rsp_stall <= 1'b0;
				@(posedge clk);
			end else begin
				hold = pick_gap();
				if (hold > 0) begin
					rsp_stall <= 1'b1;
					repeat (hold) @(posedge clk);
				end
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == STALL_LIMIT) begin
			$display("Timeout after %0d cycles without a beat", STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		logic [CMD_W-1:0]       cmd;
		logic [CHAR_W-1:0]      ch;
		logic [CODE_BITS_W-1:0] bits;
		logic [CODE_LEN_W-1:0]  len;
		int                     roll;
		int                     slot;
		for (int i = 0; i < 16; i++) begin
			known_bits[i] = '0;
			known_len[i] = '0;
			known_chars[i] = BLANK_SYMBOL;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corner cases of the trie.
		send_beat(CMD_DECODE, 8'h00, 6'h05, 3'd3);
		send_beat(CMD_ENCODE, "E", 6'h00, 3'd0);
		send_beat(CMD_ADD, "E", 6'h00, 3'd1);
		send_beat(CMD_ADD, "T", 6'h01, 3'd1);
		send_beat(CMD_ADD, "!", 6'h00, 3'd0);
		send_beat(CMD_DECODE, 8'h00, 6'h00, 3'd0);
		send_beat(CMD_DECODE, 8'hFF, 6'h00, 3'd1);
		send_beat(CMD_DECODE, 8'h00, 6'h03, 3'd2);
		send_beat(CMD_ENCODE, "T", 6'h00, 3'd0);
		send_beat(CMD_ENCODE, 8'hFF, 6'h00, 3'd0);
		send_beat(CMD_ADD, "A", 6'h02, 3'd2);
		send_beat(CMD_ADD, 8'hFF, 6'h3F, 3'd7);
		send_beat(CMD_DECODE, 8'h00, 6'h3F, 3'd6);
		send_beat(CMD_DECODE, 8'h00, 6'h3F, 3'd7);
		send_beat(CMD_ENCODE, BLANK_SYMBOL, 6'h00, 3'd0);
		send_beat(CMD_ENCODE, 8'hFF, 6'h3F, 3'd7);
		send_beat(CMD_ADD, 8'h00, 6'h00, 3'd6);
		send_beat(CMD_ENCODE, 8'h00, 6'h00, 3'd0);
		send_beat(CMD_ADD, "X", 6'h01, 3'd1);
		send_beat(CMD_CLEAR, 8'hFF, 6'h3F, 3'd7);
		send_beat(CMD_DECODE, 8'h00, 6'h00, 3'd1);
		send_beat(CMD_ENCODE, BLANK_SYMBOL, 6'h00, 3'd0);
		send_beat(CMD_ADD, "R", 6'h00, 3'd0);
		send_beat(CMD_DECODE, 8'h00, 6'h00, 3'd0);
		send_beat(CMD_ENCODE, "R", 6'h00, 3'd0);
		drain_replies();

		// Random phases: phase 2 runs without idle cycles, phase 3 holds the
		// response side off so the engine backs up into the request channel.
		for (int phase = 0; phase < PHASES; phase++) begin
			no_idle = (phase == 2);
			if (phase == 3)
				hold_off_req = 1'b1;
			repeat (PHASE_BEATS) begin
				roll = $urandom_range(0, 99);
				ch = CHAR_W'($urandom_range(0, 255));
				bits = CODE_BITS_W'($urandom_range(0, 63));
				len = CODE_LEN_W'($urandom_range(0, 7));
				slot = $urandom_range(0, 15);
				if (roll < 3) begin
					cmd = CMD_CLEAR;
				end else if (roll < 40) begin
					cmd = CMD_ADD;
					if ($urandom_range(0, 99) < 60)
						ch = CHAR_W'($urandom_range(65, 90));
					roll = $urandom_range(0, 99);
					if (roll < 8)
						len = 3'd0;
					else if (roll >= 15)
						len = CODE_LEN_W'($urandom_range(1, 6));
					known_bits[slot] = bits;
					known_len[slot] = len;
					known_chars[slot] = ch;
				end else if (roll < 72) begin
					cmd = CMD_DECODE;
					if ($urandom_range(0, 99) < 60) begin
						bits = known_bits[slot];
						len = known_len[slot];
					end
				end else begin
					cmd = CMD_ENCODE;
					roll = $urandom_range(0, 99);
					if (roll < 60)
						ch = known_chars[slot];
					else if (roll < 72)
						ch = BLANK_SYMBOL;
				end
				send_beat(cmd, ch, bits, len);
			end
			drain_replies();
		end
		no_idle = 1'b0;

		repeat (150) @(posedge clk);
		$display("Sent %0d adds, %0d decodes, %0d encodes and %0d clears; %0d replies checked.",
			beats_sent[CMD_ADD], beats_sent[CMD_DECODE], beats_sent[CMD_ENCODE],
			beats_sent[CMD_CLEAR], replies_checked);
		$display("Run included a long response hold-off and a phase with no idle cycles.");
		if (mismatch_count == 0 && replies_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
